// ----- hw/rtl/pfe_pkg.sv -----
package pfe_pkg;

    localparam int SQ_CELLS  = 25;
    localparam int N_LETTERS = 26;
    localparam int LTR_W     = 5;
    localparam int POS_W     = 6;

    localparam logic [LTR_W-1:0] LTR_I = 5'd8;
    localparam logic [LTR_W-1:0] LTR_J = 5'd9;
    localparam logic [LTR_W-1:0] LTR_Z = 5'd25;
    localparam logic [6:0]       ASCII_A_LC = 7'd97;

    typedef logic [LTR_W-1:0] letter_t;
    typedef logic [POS_W-1:0] pos_t;

    // one result item: ciphertext letter and end-of-message mark
    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } res_t;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122));
    endfunction

    function automatic letter_t letter_idx(input logic [7:0] c);
        logic [7:0] d;
        d = (c <= 8'd90) ? (c - 8'd65) : (c - 8'd97);
        return d[LTR_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/pfe_ram.sv -----
module pfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/pfe_out_buf.sv -----
module pfe_out_buf (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  pfe_pkg::res_t res0,
    input  pfe_pkg::res_t res1,
    output logic          empty,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,   // [6:0] cipher_char, [7] zero
    output logic          m_tlast    // last_result
);
    import pfe_pkg::*;

    res_t       slot0_reg, slot0_next;
    res_t       slot1_reg, slot1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign pop = m_tvalid && m_tready;

    always_comb begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        if (push) begin
            slot0_next = res0;
            slot1_next = res1;
            cnt_next   = 2'd2;
        end else if (pop) begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign empty    = (cnt_reg == 2'd0);
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {1'b0, slot0_reg.ch};
    assign m_tlast  = slot0_reg.last;

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("result buffer count out of range");
    a_push_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> empty) else $error("pair pushed over waiting results");
    a_first_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> !slot0_reg.last) else $error("first of pair marked last");
`endif

endmodule

// ----- hw/rtl/playfair_cipher_encrypt_unit.sv -----
// Playfair encryption of a byte stream. Key bytes (s_tuser = 0) build the 5x5 square in
// two small memories (letter by cell, cell by letter); the key byte with s_tlast set
// starts a fill walk over all 26 letters that adds the unused ones, during which no item is
// taken. A message byte (s_tuser = 1) that completes a pair holds the input through the
// states RD_A, RD_B, CALC, RD_O1, RD_O2 and PUSH, set by the two position reads and two
// square reads through the single read port of each memory, and then returns two result
// items through a two-entry output buffer, so the next item is taken while they drain. A
// pair that finishes before the previous pair has drained waits in PUSH until the buffer
// is empty.
// Message bytes before the first complete key are dropped; odd final letters pad with z.
module playfair_cipher_encrypt_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic       s_tuser,   // func: 0 key, 1 message
    input  logic       s_tlast,   // last_char
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] cipher_char, [7] zero
    output logic       m_tlast    // last_result
);
    import pfe_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FILL, ST_RD_A, ST_RD_B, ST_CALC, ST_RD_O1, ST_RD_O2, ST_PUSH
    } state_t;

    state_t                 state_reg, state_next;
    logic [N_LETTERS-1:0]   placed_reg, placed_next;
    logic [4:0]             fill_cnt_reg, fill_cnt_next;
    logic [2:0]             fill_row_reg, fill_row_next;
    logic [2:0]             fill_col_reg, fill_col_next;
    letter_t                walk_reg, walk_next;
    logic                   sq_ready_reg, sq_ready_next;
    letter_t                pend_reg, pend_next;
    logic                   pend_v_reg, pend_v_next;
    letter_t                a_reg, a_next;
    letter_t                b_reg, b_next;
    logic                   pair_last_reg, pair_last_next;
    pos_t                   pa_reg, pa_next;
    logic [4:0]             o1_reg, o1_next;
    logic [4:0]             o2_reg, o2_next;
    letter_t                c1_reg, c1_next;

    logic                   accept;
    logic                   in_ltr_ok;
    letter_t                in_ltr;
    letter_t                msg_ltr;
    letter_t                cand;
    logic                   place_en;
    logic [N_LETTERS-1:0]   placed_base;
    logic [4:0]             fill_base;
    logic [2:0]             row_base;
    logic [2:0]             col_base;

    logic                   ks_we, ks_re;
    logic [4:0]             ks_waddr, ks_raddr;
    letter_t                ks_rdata;
    logic                   pos_we, pos_re;
    letter_t                pos_raddr;
    pos_t                   pos_wdata, pos_rdata;

    logic [2:0]             r1, k1, r2, k2;
    logic                   buf_push, buf_empty;
    res_t                   res0, res1;

    function automatic logic [2:0] inc5(input logic [2:0] x);
        return (x == 3'd4) ? 3'd0 : x + 3'd1;
    endfunction

    function automatic logic [4:0] cell_of(input logic [2:0] r, input logic [2:0] c);
        return {r, 2'b00} + {2'b00, r} + {2'b00, c};
    endfunction

    pfe_ram #(.WIDTH(LTR_W), .DEPTH(SQ_CELLS)) u_key_square (
        .aclk  (aclk),
        .we    (ks_we),
        .waddr (ks_waddr),
        .wdata (cand),
        .re    (ks_re),
        .raddr (ks_raddr),
        .rdata (ks_rdata)
    );

    pfe_ram #(.WIDTH(POS_W), .DEPTH(N_LETTERS)) u_letter_pos (
        .aclk  (aclk),
        .we    (pos_we),
        .waddr (cand),
        .wdata (pos_wdata),
        .re    (pos_re),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign in_ltr_ok = is_letter(s_tdata);
    assign in_ltr    = letter_idx(s_tdata);
    assign msg_ltr   = (in_ltr == LTR_J) ? LTR_I : in_ltr;

    // a new key after a finished square starts from an empty square
    always_comb begin
        if (state_reg == ST_IDLE && sq_ready_reg) begin
            placed_base = '0;
            fill_base   = 5'd0;
            row_base    = 3'd0;
            col_base    = 3'd0;
        end else begin
            placed_base = placed_reg;
            fill_base   = fill_cnt_reg;
            row_base    = fill_row_reg;
            col_base    = fill_col_reg;
        end
    end

    always_comb begin
        cand     = (state_reg == ST_FILL) ? walk_reg : in_ltr;
        place_en = 1'b0;
        if (state_reg == ST_FILL) begin
            place_en = 1'b1;
        end else if (accept && !s_tuser && in_ltr_ok) begin
            place_en = 1'b1;
        end
        if (cand == LTR_J || placed_base[cand] || fill_base >= 5'(SQ_CELLS)) begin
            place_en = 1'b0;
        end
    end

    assign ks_we     = place_en;
    assign ks_waddr  = fill_base;
    assign pos_we    = place_en;
    assign pos_wdata = {row_base, col_base};

    assign r1 = pa_reg[5:3];
    assign k1 = pa_reg[2:0];
    assign r2 = pos_rdata[5:3];
    assign k2 = pos_rdata[2:0];

    always_comb begin
        pos_re    = (state_reg == ST_RD_A) || (state_reg == ST_RD_B);
        pos_raddr = (state_reg == ST_RD_A) ? a_reg : b_reg;
        ks_re     = (state_reg == ST_RD_O1) || (state_reg == ST_RD_O2);
        ks_raddr  = (state_reg == ST_RD_O1) ? o1_reg : o2_reg;
    end

    assign buf_push = (state_reg == ST_PUSH) && buf_empty;
    assign res0     = '{ch: ASCII_A_LC + {2'b00, c1_reg}, last: 1'b0};
    assign res1     = '{ch: ASCII_A_LC + {2'b00, ks_rdata}, last: pair_last_reg};

    always_comb begin
        state_next     = state_reg;
        placed_next    = placed_base;
        fill_cnt_next  = fill_base;
        fill_row_next  = row_base;
        fill_col_next  = col_base;
        walk_next      = walk_reg;
        sq_ready_next  = sq_ready_reg;
        pend_next      = pend_reg;
        pend_v_next    = pend_v_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        pair_last_next = pair_last_reg;
        pa_next        = pa_reg;
        o1_next        = o1_reg;
        o2_next        = o2_reg;
        c1_next        = c1_reg;

        if (place_en) begin
            placed_next[cand] = 1'b1;
            fill_cnt_next     = fill_base + 5'd1;
            if (col_base == 3'd4) begin
                fill_col_next = 3'd0;
                fill_row_next = row_base + 3'd1;
            end else begin
                fill_col_next = col_base + 3'd1;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (!accept) begin
                    placed_next   = placed_reg;
                    fill_cnt_next = fill_cnt_reg;
                    fill_row_next = fill_row_reg;
                    fill_col_next = fill_col_reg;
                end else if (!s_tuser) begin
                    if (sq_ready_reg) begin
                        sq_ready_next = 1'b0;
                        pend_v_next   = 1'b0;
                        pend_next     = '0;
                    end
                    if (s_tlast) begin
                        walk_next  = '0;
                        state_next = ST_FILL;
                    end
                end else if (sq_ready_reg) begin
                    if (in_ltr_ok) begin
                        if (pend_v_reg) begin
                            a_next         = pend_reg;
                            b_next         = msg_ltr;
                            pair_last_next = s_tlast;
                            pend_v_next    = 1'b0;
                            pend_next      = '0;
                            state_next     = ST_RD_A;
                        end else if (s_tlast) begin
                            a_next         = msg_ltr;
                            b_next         = LTR_Z;
                            pair_last_next = 1'b1;
                            state_next     = ST_RD_A;
                        end else begin
                            pend_next   = msg_ltr;
                            pend_v_next = 1'b1;
                        end
                    end else if (s_tlast) begin
                        if (pend_v_reg) begin
                            a_next         = pend_reg;
                            b_next         = LTR_Z;
                            pair_last_next = 1'b1;
                            state_next     = ST_RD_A;
                        end
                        pend_v_next = 1'b0;
                        pend_next   = '0;
                    end
                end
            end
            ST_FILL: begin
                if (walk_reg == LTR_Z) begin
                    sq_ready_next = 1'b1;
                    state_next    = ST_IDLE;
                end else begin
                    walk_next = walk_reg + 5'd1;
                end
            end
            ST_RD_A: begin
                state_next = ST_RD_B;
            end
            ST_RD_B: begin
                pa_next    = pos_rdata;
                state_next = ST_CALC;
            end
            ST_CALC: begin
                // doubled letters share a row and take the row rule
                if (r1 == r2) begin
                    o1_next = cell_of(r1, inc5(k1));
                    o2_next = cell_of(r2, inc5(k2));
                end else if (k1 == k2) begin
                    o1_next = cell_of(inc5(r1), k1);
                    o2_next = cell_of(inc5(r2), k2);
                end else begin
                    o1_next = cell_of(r1, k2);
                    o2_next = cell_of(r2, k1);
                end
                state_next = ST_RD_O1;
            end
            ST_RD_O1: begin
                state_next = ST_RD_O2;
            end
            ST_RD_O2: begin
                c1_next    = ks_rdata;
                state_next = ST_PUSH;
            end
            ST_PUSH: begin
                if (buf_empty) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            placed_reg   <= '0;
            fill_cnt_reg <= 5'd0;
            fill_row_reg <= 3'd0;
            fill_col_reg <= 3'd0;
            sq_ready_reg <= 1'b0;
            pend_reg     <= '0;
            pend_v_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            placed_reg   <= placed_next;
            fill_cnt_reg <= fill_cnt_next;
            fill_row_reg <= fill_row_next;
            fill_col_reg <= fill_col_next;
            sq_ready_reg <= sq_ready_next;
            pend_reg     <= pend_next;
            pend_v_reg   <= pend_v_next;
        end
        walk_reg      <= walk_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        pair_last_reg <= pair_last_next;
        pa_reg        <= pa_next;
        o1_reg        <= o1_next;
        o2_reg        <= o2_next;
        c1_reg        <= c1_next;
    end

    pfe_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (buf_push),
        .res0     (res0),
        .res1     (res1),
        .empty    (buf_empty),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTH
    a_push_needs_square: assert property (@(posedge aclk) disable iff (!aresetn)
        buf_push |-> sq_ready_reg) else $error("pair enciphered without a square");
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_cnt_reg <= 5'(SQ_CELLS)) else $error("square fill count overrun");
    a_fill_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FILL && walk_reg == LTR_Z) |=>
        (fill_cnt_reg == 5'(SQ_CELLS) && sq_ready_reg && !placed_reg[LTR_J]))
        else $error("square not complete after fill walk");
    a_pend_needs_square: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_v_reg |-> (sq_ready_reg && pend_reg != LTR_J))
        else $error("waiting letter without square or unmapped j");
`endif

endmodule
